// File: rtl/core/pwfd_pkg.sv
// shared types, codes and constants of the pulse-width frame decoder
// no dependencies; imported by every module of the block
package pwfd_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 8;
  localparam int FrameWidth    = 32;
  localparam int IndexWidth    = 6;
  localparam int ClassWidth    = 3;

  // pulse classes
  localparam logic [ClassWidth-1:0] CLS_NONE = 3'd0;
  localparam logic [ClassWidth-1:0] CLS_ZERO = 3'd1;
  localparam logic [ClassWidth-1:0] CLS_ONE  = 3'd2;
  localparam logic [ClassWidth-1:0] CLS_SYNC = 3'd3;
  localparam logic [ClassWidth-1:0] CLS_END  = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CRC_BAD   = 2'd1;
  localparam logic [1:0] ST_COUNT_BAD = 2'd2;
  localparam logic [1:0] ST_ZERO      = 2'd3;

  // register indexes
  localparam logic [CfgIndexWidth-1:0] REG_ZERO_LOW  = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_ZERO_HIGH = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_ONE_LOW   = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_ONE_HIGH  = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_SYNC_LOW  = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_SYNC_HIGH = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_END_MIN   = 3'd6;

  // register reset values
  localparam logic [7:0] ZERO_LOW_RST  = 8'd35;
  localparam logic [7:0] ZERO_HIGH_RST = 8'd45;
  localparam logic [7:0] ONE_LOW_RST   = 8'd73;
  localparam logic [7:0] ONE_HIGH_RST  = 8'd87;
  localparam logic [7:0] SYNC_LOW_RST  = 8'd110;
  localparam logic [7:0] SYNC_HIGH_RST = 8'd130;
  localparam logic [7:0] END_MIN_RST   = 8'd150;

  localparam logic [7:0] CRC_POLY = 8'h8c;
  localparam int PayloadWidth = 24;

  typedef struct packed {
    logic [7:0] zero_low;
    logic [7:0] zero_high;
    logic [7:0] one_low;
    logic [7:0] one_high;
    logic [7:0] sync_low;
    logic [7:0] sync_high;
    logic [7:0] end_min;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] value_high;
    logic [9:0]  value_low;
  } result_t;

  typedef logic [PayloadWidth-1:0][7:0] crc_cols_t;

  // crc of each single payload bit; the crc is linear so the full value
  // is the xor of the columns of the set bits
  function automatic crc_cols_t crc_columns();
    crc_cols_t  cols;
    logic [7:0] c;
    logic       fb;
    for (int i = 0; i < PayloadWidth; i++) begin
      c = '0;
      for (int j = 0; j < PayloadWidth; j++) begin
        fb = c[0] ^ (j == i);
        c  = {1'b0, c[7:1]} ^ (fb ? CRC_POLY : 8'h00);
      end
      cols[i] = c;
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC_COLS = crc_columns();

endpackage

// File: rtl/core/pwfd_classify.sv
// pulse classifier: sorts a width into zero, one, sync or end windows; a width in none keeps the last class
// depends on pwfd_pkg
module pwfd_classify import pwfd_pkg::*; (
  input  logic [7:0]            pulse_width,
  input  cfg_t                  cfg,
  input  logic [ClassWidth-1:0] last_class,
  output logic [ClassWidth-1:0] pulse_class
);

  // later windows take priority where they overlap
  always_comb begin
    pulse_class = last_class;
    if (pulse_width > cfg.zero_low && pulse_width < cfg.zero_high) begin
      pulse_class = CLS_ZERO;
    end
    if (pulse_width > cfg.one_low && pulse_width < cfg.one_high) begin
      pulse_class = CLS_ONE;
    end
    if (pulse_width > cfg.sync_low && pulse_width < cfg.sync_high) begin
      pulse_class = CLS_SYNC;
    end
    if (pulse_width > cfg.end_min) begin
      pulse_class = CLS_END;
    end
  end

endmodule

// File: rtl/core/pwfd_check.sv
// frame checker: crc-8, bit count check and zero test on a finished frame
// depends on pwfd_pkg
module pwfd_check import pwfd_pkg::*; (
  input  logic [FrameWidth-1:0] frame_bits,
  output result_t               result
);

  logic [PayloadWidth-1:0] payload;
  logic [7:0]              crc;
  logic [3:0]              count;

  assign payload = frame_bits[FrameWidth-1:8];

  always_comb begin
    crc = '0;
    for (int i = 0; i < PayloadWidth; i++) begin
      if (payload[i]) begin
        crc = crc ^ CRC_COLS[i];
      end
    end
  end

  // even payload bits 4 to 22
  always_comb begin
    count = '0;
    for (int k = 0; k < 10; k++) begin
      count = count + 4'(payload[4 + 2 * k]);
    end
  end

  always_comb begin
    result = '0;
    if (crc != frame_bits[7:0]) begin
      result.status = ST_CRC_BAD;
    end else if (count[2:0] != payload[2:0]) begin
      result.status = ST_COUNT_BAD;
    end else if (payload == '0) begin
      result.status = ST_ZERO;
    end else begin
      result.status     = ST_OK;
      result.value_high = payload[23:13];
      result.value_low  = payload[12:3];
    end
  end

endmodule

// File: rtl/core/pulse_width_frame_decoder_crc8_unit.sv
// top level of the pulse-width frame decoder with crc-8 check
// depends on pwfd_pkg, pwfd_classify and pwfd_check
//
//   channel | signals                               | role
//   --------+---------------------------------------+-------------------------
//   in      | in_valid, in_ready, pulse_width       | one measured width
//   out     | out_valid, out_ready, status, value_* | one result per end pulse
//   cfg     | cfg_we, cfg_index, cfg_data           | window register writes
//
// one item per cycle unless an end pulse waits on a full result register;
// an item is held in the input register, where classification, frame
// update and checking run, and an end pulse moves from there into the
// result register, which raises out_valid.
// reset restores the window registers and clears frame, index and class.
// only an end pulse waits on a full result register; other items pass on.
module pulse_width_frame_decoder_crc8_unit import pwfd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               pulse_width,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic [10:0]              value_high,
  output logic [9:0]               value_low,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  cfg_t                  cfg;
  logic                  s1_valid;
  logic [7:0]            s1_width;
  logic [FrameWidth-1:0] frame_bits;
  logic [FrameWidth-1:0] frame_bits_next;
  logic [IndexWidth-1:0] bit_index;
  logic [IndexWidth-1:0] bit_index_next;
  logic [ClassWidth-1:0] last_class;
  logic [ClassWidth-1:0] pulse_class;
  logic                  emit;
  logic                  out_free;
  logic                  s1_go;
  logic                  s1_fire;
  result_t               result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_low  <= ZERO_LOW_RST;
      cfg.zero_high <= ZERO_HIGH_RST;
      cfg.one_low   <= ONE_LOW_RST;
      cfg.one_high  <= ONE_HIGH_RST;
      cfg.sync_low  <= SYNC_LOW_RST;
      cfg.sync_high <= SYNC_HIGH_RST;
      cfg.end_min   <= END_MIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ZERO_LOW:  cfg.zero_low  <= cfg_data;
        REG_ZERO_HIGH: cfg.zero_high <= cfg_data;
        REG_ONE_LOW:   cfg.one_low   <= cfg_data;
        REG_ONE_HIGH:  cfg.one_high  <= cfg_data;
        REG_SYNC_LOW:  cfg.sync_low  <= cfg_data;
        REG_SYNC_HIGH: cfg.sync_high <= cfg_data;
        REG_END_MIN:   cfg.end_min   <= cfg_data;
        default: ;
      endcase
    end
  end

  pwfd_classify u_classify (
    .pulse_width (s1_width),
    .cfg         (cfg),
    .last_class  (last_class),
    .pulse_class (pulse_class)
  );

  pwfd_check u_check (
    .frame_bits (frame_bits),
    .result     (result)
  );

  assign emit     = (pulse_class == CLS_END);
  assign out_free = !out_valid || out_ready;
  assign s1_go    = !emit || out_free;
  assign s1_fire  = s1_valid && s1_go;
  assign in_ready = !s1_valid || s1_go;

  always_comb begin
    frame_bits_next = frame_bits;
    bit_index_next  = bit_index;
    case (pulse_class)
      CLS_ONE: begin
        if (!bit_index[IndexWidth-1]) begin
          frame_bits_next[bit_index[IndexWidth-2:0]] = 1'b1;
          bit_index_next = bit_index + 1'b1;
        end
      end
      CLS_ZERO: begin
        if (!bit_index[IndexWidth-1]) begin
          bit_index_next = bit_index + 1'b1;
        end
      end
      CLS_SYNC, CLS_END: begin
        frame_bits_next = '0;
        bit_index_next  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      frame_bits <= '0;
      bit_index  <= '0;
      last_class <= CLS_NONE;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        frame_bits <= frame_bits_next;
        bit_index  <= bit_index_next;
        last_class <= pulse_class;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_width <= pulse_width;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      status     <= result.status;
      value_high <= result.value_high;
      value_low  <= result.value_low;
    end
  end

`ifndef SYNTHESIS
  a_index_sat: assert property (@(posedge clk) disable iff (rst)
    bit_index <= IndexWidth'(FrameWidth))
    else $error("bit index beyond frame");

  a_bits_below_index: assert property (@(posedge clk) disable iff (rst)
    !bit_index[IndexWidth-1] |-> ((frame_bits >> bit_index) == '0))
    else $error("frame bit set at or above bit index");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && emit |=> frame_bits == '0 && bit_index == '0)
    else $error("frame not cleared after end pulse");

  a_fail_zero_values: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> value_high == '0 && value_low == '0)
    else $error("value fields set on a failed frame");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_width))
    else $error("stalled item lost from input register");
`endif

endmodule

// File: tb/pulse_width_frame_decoder_crc8_unit_test.sv
// self-checking testbench for the pulse-width frame decoder with crc-8 check
// depends on pwfd_pkg and pulse_width_frame_decoder_crc8_unit; drives widths,
// predicts every result frame and checks it against the block's output channel
module pulse_width_frame_decoder_crc8_unit_test;
  import pwfd_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [7:0]               pulse_width = 8'd0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               status;
  logic [10:0]              value_high;
  logic [9:0]               value_low;
  logic                     cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data = '0;

  pulse_width_frame_decoder_crc8_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pulse_width(pulse_width),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .value_high (value_high),
    .value_low  (value_low),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  typedef enum int {FR_GOOD, FR_BAD_CRC, FR_BAD_COUNT, FR_EMPTY, FR_MANGLED} frame_kind_t;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted decoder state
  cfg_t                  win;
  logic [FrameWidth-1:0] frame_acc = '0;
  logic [IndexWidth-1:0] bit_pos = '0;
  logic [ClassWidth-1:0] prev_class = CLS_NONE;

  logic [7:0] widths_to_send[$];
  result_t    frames_due[$];
  int         errors = 0;

  // sender and receiver pacing
  logic width_taken = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  logic rx_hold = 1'b0;
  logic rx_go;
  int   rx_cycle = 0;
  int   rx_mode = 0;
  result_t want;

  function automatic logic [ClassWidth-1:0] class_of(input logic [7:0] w);
    logic [ClassWidth-1:0] c;
    c = CLS_NONE;
    // later windows take priority when they overlap
    if (w > win.zero_low && w < win.zero_high) c = CLS_ZERO;
    if (w > win.one_low && w < win.one_high) c = CLS_ONE;
    if (w > win.sync_low && w < win.sync_high) c = CLS_SYNC;
    if (w > win.end_min) c = CLS_END;
    return c;
  endfunction

  function automatic logic [7:0] crc8_of(input logic [PayloadWidth-1:0] payload);
    logic [7:0] crc;
    crc = 8'h00;
    for (int b = 0; b < 3; b++) begin
      crc = crc ^ payload[8*b +: 8];
      for (int k = 0; k < 8; k++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  function automatic logic [2:0] spaced_bit_count(input logic [PayloadWidth-1:0] payload);
    logic [2:0] n;
    n = '0;
    for (int pos = 4; pos <= 22; pos += 2) n = n + 3'(payload[pos]);
    return n;
  endfunction

  task automatic decode_pulse(input logic [7:0] w);
    logic [ClassWidth-1:0]   c;
    logic [PayloadWidth-1:0] payload;
    result_t                 r;
    c = class_of(w);
    // an unclassified width keeps the previous class
    if (c != CLS_NONE) prev_class = c;
    case (prev_class)
      CLS_ONE: begin
        if (bit_pos < FrameWidth) begin
          frame_acc[bit_pos] = 1'b1;
          bit_pos++;
        end
      end
      CLS_ZERO: begin
        if (bit_pos < FrameWidth) bit_pos++;
      end
      CLS_SYNC: begin
        frame_acc = '0;
        bit_pos = '0;
      end
      CLS_END: begin
        payload = frame_acc[FrameWidth-1:8];
        r = '0;
        if (crc8_of(payload) != frame_acc[7:0]) begin
          r.status = ST_CRC_BAD;
        end else if (spaced_bit_count(payload) != payload[2:0]) begin
          r.status = ST_COUNT_BAD;
        end else if (payload == '0) begin
          r.status = ST_ZERO;
        end else begin
          r.status = ST_OK;
          r.value_high = payload[23:13];
          r.value_low = payload[12:3];
        end
        frames_due.push_back(r);
        frame_acc = '0;
        bit_pos = '0;
      end
      default: ;
    endcase
  endtask

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // input side: accept at the rising edge, offer the next item at the falling edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      decode_pulse(pulse_width);
      width_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!in_valid || width_taken)) begin
      width_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (widths_to_send.size() != 0) begin
        pulse_width <= widths_to_send.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          if ($urandom_range(3, 0) == 0) begin
            burst_left = $urandom_range(80, 30);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(16, 1);
            gap_left = $urandom_range(8, 0);
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side: the stall pattern switches among random modes as the run goes on
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 48 == 0) rx_mode = $urandom_range(3, 0);
    case (rx_mode)
      0: rx_go = 1'b1;
      1: rx_go = 1'($urandom_range(1, 0));
      2: rx_go = ($urandom_range(3, 0) == 0);
      default: rx_go = (rx_cycle % 8 != 0);
    endcase
    out_ready <= rx_go && !rx_hold;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (frames_due.size() == 0) begin
        note_error($sformatf("unexpected result: status %0d high %0d low %0d",
                             status, value_high, value_low));
      end else begin
        want = frames_due.pop_front();
        if (status !== want.status || value_high !== want.value_high ||
            value_low !== want.value_low) begin
          note_error($sformatf("result mismatch: status %0d/%0d high %0d/%0d low %0d/%0d",
                               want.status, status, want.value_high, value_high,
                               want.value_low, value_low));
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic write_windows(input cfg_t c);
    write_reg(REG_ZERO_LOW, c.zero_low);
    write_reg(REG_ZERO_HIGH, c.zero_high);
    write_reg(REG_ONE_LOW, c.one_low);
    write_reg(REG_ONE_HIGH, c.one_high);
    write_reg(REG_SYNC_LOW, c.sync_low);
    write_reg(REG_SYNC_HIGH, c.sync_high);
    write_reg(REG_END_MIN, c.end_min);
    @(negedge clk);
    cfg_we <= 1'b0;
    win = c;
  endtask

  // wait for all items sent and all results back, then let the pipe settle
  task automatic drain();
    while (widths_to_send.size() != 0 || in_valid || frames_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_width(input logic [ClassWidth-1:0] cls);
    logic [7:0] w;
    int lo;
    int hi;
    case (cls)
      CLS_ZERO: begin lo = win.zero_low + 1; hi = win.zero_high - 1; end
      CLS_ONE:  begin lo = win.one_low + 1;  hi = win.one_high - 1;  end
      CLS_SYNC: begin lo = win.sync_low + 1; hi = win.sync_high - 1; end
      CLS_END:  begin lo = win.end_min + 1;  hi = 255;               end
      default:  begin lo = 0;                hi = 255;               end
    endcase
    w = 8'd0;
    for (int t = 0; t < 40; t++) begin
      if (lo <= hi) w = 8'($urandom_range(hi, lo));
      else w = 8'($urandom_range(255, 0));
      if (class_of(w) == cls) return w;
    end
    return w;
  endfunction

  task automatic queue_noise(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(4, 0) < 2) widths_to_send.push_back(pick_width(CLS_NONE));
      else widths_to_send.push_back(8'($urandom_range(255, 0)));
    end
  endtask

  task automatic queue_frame();
    frame_kind_t             kind;
    int                      roll;
    logic [PayloadWidth-1:0] p;
    logic [7:0]              crc;
    logic [FrameWidth-1:0]   f;
    int                      nbits;
    roll = $urandom_range(99, 0);
    if (roll < 60) kind = FR_GOOD;
    else if (roll < 70) kind = FR_BAD_CRC;
    else if (roll < 80) kind = FR_BAD_COUNT;
    else if (roll < 85) kind = FR_EMPTY;
    else kind = FR_MANGLED;
    p = PayloadWidth'($urandom);
    if ($urandom_range(3, 0) == 0) begin
      p = p & PayloadWidth'($urandom) & PayloadWidth'($urandom);
    end
    p[2:0] = spaced_bit_count(p);
    if (kind == FR_BAD_COUNT) p[2:0] = p[2:0] + 3'd1;
    if (kind == FR_EMPTY) p = '0;
    crc = crc8_of(p);
    if (kind == FR_BAD_CRC) crc[$urandom_range(7, 0)] ^= 1'b1;
    f = {p, crc};
    nbits = FrameWidth;
    // a few extra bits past a full frame must leave it untouched
    if (kind == FR_GOOD && $urandom_range(6, 0) == 0) nbits += $urandom_range(3, 1);
    if (kind == FR_MANGLED) nbits = $urandom_range(36, 20);
    if ($urandom_range(4, 0) != 0) widths_to_send.push_back(pick_width(CLS_SYNC));
    for (int i = 0; i < nbits; i++) begin
      if (i < FrameWidth) begin
        widths_to_send.push_back(pick_width(f[i] ? CLS_ONE : CLS_ZERO));
      end else begin
        widths_to_send.push_back(pick_width($urandom_range(1, 0) ? CLS_ONE : CLS_ZERO));
      end
      if (kind == FR_MANGLED && $urandom_range(15, 0) == 0) queue_noise(1);
    end
    widths_to_send.push_back(pick_width(CLS_END));
    // an unclassified width right after an end repeats the end
    if ($urandom_range(9, 0) == 0) widths_to_send.push_back(pick_width(CLS_NONE));
  endtask

  task automatic queue_traffic(input int frames);
    for (int i = 0; i < frames; i++) begin
      queue_frame();
      queue_noise($urandom_range(3, 0));
    end
  endtask

  task automatic random_windows();
    int   b[7];
    cfg_t c;
    for (int i = 0; i < 7; i++) b[i] = i * 34 + $urandom_range(30, 0);
    if ($urandom_range(1, 0)) begin
      c.zero_low = 8'(b[0]); c.zero_high = 8'(b[1]);
      c.one_low = 8'(b[2]); c.one_high = 8'(b[3]);
    end else begin
      c.one_low = 8'(b[0]); c.one_high = 8'(b[1]);
      c.zero_low = 8'(b[2]); c.zero_high = 8'(b[3]);
    end
    c.sync_low = 8'(b[4]);
    c.sync_high = 8'(b[5]);
    c.end_min = 8'(b[6]);
    write_windows(c);
  endtask

  initial begin
    cfg_t c;
    win = '{zero_low: ZERO_LOW_RST, zero_high: ZERO_HIGH_RST, one_low: ONE_LOW_RST,
            one_high: ONE_HIGH_RST, sync_low: SYNC_LOW_RST, sync_high: SYNC_HIGH_RST,
            end_min: END_MIN_RST};
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed: window edges, nothing classified yet, repeated end
    widths_to_send = '{8'd0, 8'd34, 8'd255, 8'd35, 8'd36, 8'd44, 8'd45, 8'd74, 8'd86,
                       8'd73, 8'd87, 8'd111, 8'd129, 8'd110, 8'd130, 8'd150, 8'd151,
                       8'd128, 8'd1, 8'd127, 8'd255};
    queue_traffic(2);
    drain();

    // receiver holds off while ends keep arriving, so the input stalls
    fork
      begin
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (150) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    for (int i = 0; i < 30; i++) widths_to_send.push_back(pick_width(CLS_END));
    queue_traffic(1);
    drain();

    // every register at its lowest, then at its highest
    c = '0;
    write_windows(c);
    queue_noise(20);
    drain();
    c = '1;
    write_windows(c);
    queue_noise(20);
    drain();

    // overlapping windows
    c = '{zero_low: 8'd20, zero_high: 8'd200, one_low: 8'd60, one_high: 8'd120,
          sync_low: 8'd100, sync_high: 8'd110, end_min: 8'd230};
    write_windows(c);
    queue_traffic(1);
    queue_noise(10);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      random_windows();
      queue_traffic(1);
      drain();
    end

    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
